// ===== hw/rtl/nmea_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_chk_pkg
// Shared codes, character constants and helpers for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nmea_chk_pkg;

  // ASCII characters of interest
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Three-character type tags as seen in the sliding window
  localparam logic [23:0] WIN_GGA = 24'h474741;
  localparam logic [23:0] WIN_RMC = 24'h524D43;
  localparam logic [23:0] WIN_GSA = 24'h475341;
  localparam logic [23:0] WIN_GSV = 24'h475356;

  // Sentence kind codes
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_RMC   = 3'd2;
  localparam logic [2:0] KIND_GSA   = 3'd3;
  localparam logic [2:0] KIND_GSV   = 3'd4;

  // Checksum status codes
  localparam logic [1:0] CS_NONE     = 2'd0;
  localparam logic [1:0] CS_MATCH    = 2'd1;
  localparam logic [1:0] CS_MISMATCH = 2'd2;

  // First-comma tracking
  typedef enum logic [1:0] {
    COMMA_NONE  = 2'd0,
    COMMA_LATE  = 2'd1,
    COMMA_EARLY = 2'd2
  } comma_t;

  // Type hit bit positions
  localparam int HIT_GGA = 0;
  localparam int HIT_RMC = 1;
  localparam int HIT_GSA = 2;
  localparam int HIT_GSV = 3;

  // Event counter slots
  localparam int EV_GGA = 0;
  localparam int EV_RMC = 1;
  localparam int EV_GSA = 2;
  localparam int EV_GSV = 3;
  localparam int EV_ERR = 4;
  localparam int EV_NUM = 5;

  // Uppercase hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'b0, n};
    end else begin
      r = 8'h41 + {4'b0, n} - 8'd10;
    end
    return r;
  endfunction

  // Map uppercase letters to lowercase, everything else unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] x);
    logic [7:0] r;
    if (x >= 8'h41 && x <= 8'h5A) begin
      r = x + 8'h20;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/nmea_sentence_checker_unit.sv =====
// Flow: an accepted byte waits in the input register until it is processed; a verdict
//   it causes is registered in the result register and shown on the out_ port.
// Throughput: one byte per cycle while no verdict word is stalled; the line state update is
//   combinational logic between the input register and the result register.
// Reset: synchronous, active low; clears line state, counters and valids.
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit
// Per-byte NMEA line tracker: type detection, XOR checksum check and
// wrapping event counters, one verdict per completed '$' line longer than five characters.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_unit #(
  parameter int LINE_STORE        = 512,
  parameter int TYPE_PREFIX_LIMIT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // verdict output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_sentence_kind,
  output logic [1:0]  out_checksum_state,
  output logic        out_accepted,
  output logic [8:0]  out_sentence_length,
  output logic [31:0] out_gga_count,
  output logic [31:0] out_rmc_count,
  output logic [31:0] out_gsa_count,
  output logic [31:0] out_gsv_count,
  output logic [31:0] out_checksum_error_count
);
  import nmea_chk_pkg::*;

  localparam int LC_W = $clog2(LINE_STORE);
  localparam logic [LC_W-1:0] CNT_FULL = LC_W'(LINE_STORE - 1);
  localparam logic [31:0]     PFX_LAST = 32'(TYPE_PREFIX_LIMIT - 1);

  // input register
  logic            in_vld_r;
  logic [7:0]      in_byte_r;

  // line state
  logic [LC_W-1:0] cnt_r,    cnt_nxt;
  logic            dollar_r, dollar_nxt;
  logic [7:0]      xor_r,    xor_nxt;
  logic            star_r,   star_nxt;
  logic            early_r,  early_nxt;
  logic [15:0]     sum_r,    sum_nxt;
  logic [1:0]      digs_r,   digs_nxt;
  comma_t          comma_r,  comma_nxt;
  logic [23:0]     win_r,    win_nxt;
  logic [3:0]      hits_r,   hits_nxt;

  // counters and result register
  logic [31:0]     ev_r [EV_NUM];
  logic [31:0]     ev_nxt [EV_NUM];
  logic            out_vld_r;
  logic [2:0]      kind_r;
  logic [1:0]      cs_r;
  logic [8:0]      len_r;

  // handshake
  logic            proc_go;
  logic            in_take;
  logic            fire;
  logic            verdict;
  logic [2:0]      kind_c;
  logic [1:0]      cs_c;

  assign proc_go  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !proc_go;
  assign in_take  = in_valid && !in_stall;
  assign fire     = in_vld_r && proc_go;

  // ---- line state update for one byte ----
  always_comb begin
    logic [7:0]      c;
    logic            is_print;
    logic            do_hold;
    logic            do_clear;
    logic [LC_W-1:0] b_cnt;
    logic            b_dollar;
    logic [7:0]      b_xor;
    logic            b_star;
    logic            b_early;
    logic [15:0]     b_sum;
    logic [1:0]      b_digs;
    comma_t          b_comma;
    logic [23:0]     b_win;
    logic [3:0]      b_hits;
    logic [23:0]     w;
    logic [31:0]     i32;

    c        = in_byte_r;
    is_print = (c >= CH_SPACE) && (c <= CH_TILDE);
    do_hold  = 1'b0;
    do_clear = 1'b0;
    verdict  = 1'b0;

    if (fire) begin
      if (c == CH_CR) begin
        do_hold = 1'b0;
      end else if (c != CH_LF) begin
        if (cnt_r < CNT_FULL && is_print) begin
          do_hold = 1'b1;
        end else if (c == CH_DOLLAR) begin
          do_clear = 1'b1;
          do_hold  = 1'b1;
        end
      end else begin
        do_clear = 1'b1;
        verdict  = (cnt_r > LC_W'(5)) && dollar_r;
      end
    end

    // starting point: current line or an empty one
    if (do_clear) begin
      b_cnt = '0; b_dollar = 1'b0; b_xor = '0; b_star = 1'b0; b_early = 1'b0;
      b_sum = '0; b_digs = '0; b_comma = COMMA_NONE; b_win = '0; b_hits = '0;
    end else begin
      b_cnt = cnt_r; b_dollar = dollar_r; b_xor = xor_r; b_star = star_r;
      b_early = early_r; b_sum = sum_r; b_digs = digs_r; b_comma = comma_r;
      b_win = win_r; b_hits = hits_r;
    end

    cnt_nxt = b_cnt; dollar_nxt = b_dollar; xor_nxt = b_xor; star_nxt = b_star;
    early_nxt = b_early; sum_nxt = b_sum; digs_nxt = b_digs; comma_nxt = b_comma;
    win_nxt = b_win; hits_nxt = b_hits;

    w   = {b_win[15:0], c};
    i32 = 32'(b_cnt);

    if (do_hold) begin
      if (b_cnt == '0 && c == CH_DOLLAR) dollar_nxt = 1'b1;
      win_nxt = w;
      // checksum body and the two digits after the first '*'
      if (!b_star) begin
        if (c == CH_STAR) begin
          star_nxt  = 1'b1;
          early_nxt = (i32 < 32'd4);
        end else if (i32 >= 32'd1) begin
          xor_nxt = b_xor ^ c;
        end
      end else if (b_digs < 2'd2) begin
        sum_nxt  = {b_sum[7:0], c};
        digs_nxt = b_digs + 2'd1;
      end
      // type prefix scan up to the first comma
      if (b_comma == COMMA_NONE) begin
        if (c == CH_COMMA) begin
          comma_nxt = (i32 >= 32'd5) ? COMMA_LATE : COMMA_EARLY;
        end else if (i32 >= 32'd3 && i32 <= PFX_LAST) begin
          if (w == WIN_GGA) hits_nxt[HIT_GGA] = 1'b1;
          if (w == WIN_RMC) hits_nxt[HIT_RMC] = 1'b1;
          if (w == WIN_GSA) hits_nxt[HIT_GSA] = 1'b1;
          if (w == WIN_GSV) hits_nxt[HIT_GSV] = 1'b1;
        end
      end
      cnt_nxt = b_cnt + LC_W'(1);
    end
  end

  // ---- verdict of the completed line ----
  always_comb begin
    logic ok;
    kind_c = KIND_OTHER;
    if (comma_r == COMMA_LATE) begin
      priority if (hits_r[HIT_GGA]) kind_c = KIND_GGA;
      else if (hits_r[HIT_RMC])     kind_c = KIND_RMC;
      else if (hits_r[HIT_GSA])     kind_c = KIND_GSA;
      else if (hits_r[HIT_GSV])     kind_c = KIND_GSV;
      else                          kind_c = KIND_OTHER;
    end
    ok = (fold_case(sum_r[15:8]) == fold_case(hex_char(xor_r[7:4]))) &&
         (fold_case(sum_r[7:0])  == fold_case(hex_char(xor_r[3:0])));
    if (star_r && !early_r && digs_r == 2'd2) begin
      cs_c = ok ? CS_MATCH : CS_MISMATCH;
    end else begin
      cs_c = CS_NONE;
    end
  end

  // ---- counter update ----
  always_comb begin
    for (int k = 0; k < EV_NUM; k++) ev_nxt[k] = ev_r[k];
    if (verdict) begin
      if (kind_c == KIND_GGA) ev_nxt[EV_GGA] = ev_r[EV_GGA] + 32'd1;
      if (kind_c == KIND_RMC) ev_nxt[EV_RMC] = ev_r[EV_RMC] + 32'd1;
      if (kind_c == KIND_GSA) ev_nxt[EV_GSA] = ev_r[EV_GSA] + 32'd1;
      if (kind_c == KIND_GSV) ev_nxt[EV_GSV] = ev_r[EV_GSV] + 32'd1;
      if (cs_c == CS_MISMATCH) ev_nxt[EV_ERR] = ev_r[EV_ERR] + 32'd1;
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      dollar_r  <= 1'b0;
      xor_r     <= '0;
      star_r    <= 1'b0;
      early_r   <= 1'b0;
      sum_r     <= '0;
      digs_r    <= '0;
      comma_r   <= COMMA_NONE;
      win_r     <= '0;
      hits_r    <= '0;
      for (int k = 0; k < EV_NUM; k++) ev_r[k] <= '0;
    end else begin
      // input register
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (proc_go) begin
        in_vld_r <= 1'b0;
      end
      // result register valid
      if (verdict) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      cnt_r    <= cnt_nxt;
      dollar_r <= dollar_nxt;
      xor_r    <= xor_nxt;
      star_r   <= star_nxt;
      early_r  <= early_nxt;
      sum_r    <= sum_nxt;
      digs_r   <= digs_nxt;
      comma_r  <= comma_nxt;
      win_r    <= win_nxt;
      hits_r   <= hits_nxt;
      for (int k = 0; k < EV_NUM; k++) ev_r[k] <= ev_nxt[k];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_rx_byte;
    if (verdict) begin
      kind_r <= kind_c;
      cs_r   <= cs_c;
      len_r  <= 9'({{9{1'b0}}, cnt_r});
    end
  end

  assign out_valid                = out_vld_r;
  assign out_sentence_kind        = kind_r;
  assign out_checksum_state       = cs_r;
  assign out_accepted             = (cs_r != CS_MISMATCH);
  assign out_sentence_length      = len_r;
  assign out_gga_count            = ev_r[EV_GGA];
  assign out_rmc_count            = ev_r[EV_RMC];
  assign out_gsa_count            = ev_r[EV_GSA];
  assign out_gsv_count            = ev_r[EV_GSV];
  assign out_checksum_error_count = ev_r[EV_ERR];

endmodule

// ===== hw/rtl/nmea_chk_assert.sv =====
// ----------------------------------------------------------------------------
// nmea_chk_assert
// Port-level checks for the NMEA sentence checker, bound to the top level.
// ----------------------------------------------------------------------------
module nmea_chk_assert (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_sentence_kind,
  input logic [1:0]  out_checksum_state,
  input logic        out_accepted,
  input logic [8:0]  out_sentence_length,
  input logic [31:0] out_checksum_error_count
);
  import nmea_chk_pkg::*;

  // a held verdict word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sentence_kind) &&
      $stable(out_checksum_state) && $stable(out_sentence_length))
    else $error("verdict changed while stalled");

  // accepted flag follows the checksum status
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_accepted == (out_checksum_state != CS_MISMATCH))
    else $error("accepted flag inconsistent with checksum status");

  // only lines longer than five characters give a verdict
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sentence_length > 9'd5)
    else $error("verdict for short line");

  // error counter only moves on a mismatch word
  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall ##1 out_valid &&
      out_checksum_state != CS_MISMATCH && $past(out_valid) |->
      out_checksum_error_count == $past(out_checksum_error_count))
    else $error("error counter moved without mismatch");

  // the byte side is held off only behind a stalled verdict word
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("byte input stalled without a held verdict");

endmodule

bind nmea_sentence_checker_unit nmea_chk_assert u_nmea_chk_assert (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_stall                 (in_stall),
  .out_valid                (out_valid),
  .out_stall                (out_stall),
  .out_sentence_kind        (out_sentence_kind),
  .out_checksum_state       (out_checksum_state),
  .out_accepted             (out_accepted),
  .out_sentence_length      (out_sentence_length),
  .out_checksum_error_count (out_checksum_error_count)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NMEA sentence checker. Byte streams go in as
// directed lines (type tags, checksum forms, comma and star positions, short,
// unanchored and overfull lines, dropped bytes), then random sentences, noise
// lines and raw bytes. A scoreboard tracks the line state of every accepted
// byte and compares each verdict word field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nmea_chk_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  cs;
    logic        acc;
    logic [8:0]  len;
    logic [31:0] gga;
    logic [31:0] rmc;
    logic [31:0] gsa;
    logic [31:0] gsv;
    logic [31:0] err;
  } verdict_t;

  // Line tracker and verdict queue
  class verdict_board;
    localparam int LINE_MAX   = 512;
    localparam int PREFIX_MAX = 32;

    int          held;
    bit          lead_dollar;
    logic [7:0]  running_xor;
    bit          star_seen;
    bit          star_soon;
    logic [15:0] digits;
    int          n_digits;
    comma_t      first_comma;
    logic [23:0] window;
    logic [3:0]  hits;
    logic [31:0] tally [EV_NUM];
    verdict_t    pending [$];
    int          errors;
    int          made;

    function new();
      reset_line();
      foreach (tally[k]) tally[k] = '0;
      errors = 0;
      made   = 0;
    endfunction

    function void reset_line();
      held        = 0;
      lead_dollar = 0;
      running_xor = '0;
      star_seen   = 0;
      star_soon   = 0;
      digits      = '0;
      n_digits    = 0;
      first_comma = COMMA_NONE;
      window      = '0;
      hits        = '0;
    endfunction

    function logic [7:0] nibble_hex(logic [3:0] n);
      string hexset;
      hexset = "0123456789ABCDEF";
      return hexset[n];
    endfunction

    function logic [7:0] to_lower(logic [7:0] x);
      if (x >= 8'h41 && x <= 8'h5A) return x | 8'h20;
      return x;
    endfunction

    // one printable character joins the line
    function void take_char(logic [7:0] c);
      int i;
      i = held;
      if (i == 0 && c == CH_DOLLAR) lead_dollar = 1;
      window = {window[15:0], c};
      if (!star_seen) begin
        if (c == CH_STAR) begin
          star_seen = 1;
          star_soon = (i < 4);
        end else if (i >= 1) begin
          running_xor = running_xor ^ c;
        end
      end else if (n_digits < 2) begin
        digits   = {digits[7:0], c};
        n_digits = n_digits + 1;
      end
      if (first_comma == COMMA_NONE) begin
        if (c == CH_COMMA) begin
          if (i >= 5) first_comma = COMMA_LATE;
          else first_comma = COMMA_EARLY;
        end else if (i >= 3 && i <= PREFIX_MAX - 1) begin
          if (window == WIN_GGA) hits[HIT_GGA] = 1'b1;
          if (window == WIN_RMC) hits[HIT_RMC] = 1'b1;
          if (window == WIN_GSA) hits[HIT_GSA] = 1'b1;
          if (window == WIN_GSV) hits[HIT_GSV] = 1'b1;
        end
      end
      held = i + 1;
    endfunction

    // accepted input byte; a line feed may queue one verdict
    function void note_byte(logic [7:0] c);
      verdict_t   v;
      logic [2:0] kind;
      logic [1:0] cs;
      bit         ok;
      if (c == CH_CR) return;
      if (c != CH_LF) begin
        if (held < LINE_MAX - 1 && c >= CH_SPACE && c <= CH_TILDE) begin
          take_char(c);
        end else if (c == CH_DOLLAR) begin
          reset_line();
          take_char(c);
        end
        return;
      end
      if (!(held > 5 && lead_dollar)) begin
        reset_line();
        return;
      end
      kind = KIND_OTHER;
      if (first_comma == COMMA_LATE) begin
        if (hits[HIT_GGA]) kind = KIND_GGA;
        else if (hits[HIT_RMC]) kind = KIND_RMC;
        else if (hits[HIT_GSA]) kind = KIND_GSA;
        else if (hits[HIT_GSV]) kind = KIND_GSV;
      end
      case (kind)
        KIND_GGA: tally[EV_GGA] = tally[EV_GGA] + 32'd1;
        KIND_RMC: tally[EV_RMC] = tally[EV_RMC] + 32'd1;
        KIND_GSA: tally[EV_GSA] = tally[EV_GSA] + 32'd1;
        KIND_GSV: tally[EV_GSV] = tally[EV_GSV] + 32'd1;
        default: ;
      endcase
      cs = CS_NONE;
      if (star_seen && !star_soon && n_digits == 2) begin
        ok = to_lower(digits[15:8]) == to_lower(nibble_hex(running_xor[7:4])) &&
             to_lower(digits[7:0]) == to_lower(nibble_hex(running_xor[3:0]));
        if (ok) begin
          cs = CS_MATCH;
        end else begin
          cs = CS_MISMATCH;
          tally[EV_ERR] = tally[EV_ERR] + 32'd1;
        end
      end
      v.kind = kind;
      v.cs   = cs;
      v.acc  = (cs != CS_MISMATCH);
      v.len  = held[8:0];
      v.gga  = tally[EV_GGA];
      v.rmc  = tally[EV_RMC];
      v.gsa  = tally[EV_GSA];
      v.gsv  = tally[EV_GSV];
      v.err  = tally[EV_ERR];
      pending = {pending, v};
      made = made + 1;
      reset_line();
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors = errors + 1;
      end
    endfunction

    // verdict word taken from the block
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected verdict, expected none actual kind %0d length %0d",
                 $time, got.kind, got.len);
        errors = errors + 1;
        return;
      end
      want = pending.pop_front();
      cmp("sentence_kind", 32'(want.kind), 32'(got.kind));
      cmp("checksum_state", 32'(want.cs), 32'(got.cs));
      cmp("accepted", 32'(want.acc), 32'(got.acc));
      cmp("sentence_length", 32'(want.len), 32'(got.len));
      cmp("gga_count", want.gga, got.gga);
      cmp("rmc_count", want.rmc, got.rmc);
      cmp("gsa_count", want.gsa, got.gsa);
      cmp("gsv_count", want.gsv, got.gsv);
      cmp("checksum_error_count", want.err, got.err);
    endfunction
  endclass

  // checksum field forms appended to a sentence
  localparam int SUM_GOOD_UP   = 0;
  localparam int SUM_GOOD_LO   = 1;
  localparam int SUM_BAD       = 2;
  localparam int SUM_NONE      = 3;
  localparam int SUM_ONE_DIGIT = 4;
  localparam int SUM_STAR_ONLY = 5;

  localparam int RANDOM_BYTES = 150;
  localparam int PHASE2_BYTES = 50;
  localparam int HOLD_CYCLES  = 150;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_sentence_kind;
  logic [1:0]  out_checksum_state;
  logic        out_accepted;
  logic [8:0]  out_sentence_length;
  logic [31:0] out_gga_count;
  logic [31:0] out_rmc_count;
  logic [31:0] out_gsa_count;
  logic [31:0] out_gsv_count;
  logic [31:0] out_checksum_error_count;

  verdict_board sb;
  logic [7:0]   line_q [$];
  int           n_sent = 0;
  int           send_idle_pct = 16;
  int           recv_stall_pct = 74;
  bit           hold_go = 0;

  nmea_sentence_checker_unit u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_rx_byte               (in_rx_byte),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_sentence_kind        (out_sentence_kind),
    .out_checksum_state       (out_checksum_state),
    .out_accepted             (out_accepted),
    .out_sentence_length      (out_sentence_length),
    .out_gga_count            (out_gga_count),
    .out_rmc_count            (out_rmc_count),
    .out_gsa_count            (out_gsa_count),
    .out_gsv_count            (out_gsv_count),
    .out_checksum_error_count (out_checksum_error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // line assembly helpers
  function automatic void put_byte(logic [7:0] b);
    line_q = {line_q, b};
  endfunction

  task automatic add_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) put_byte(s[k]);
  endtask

  task automatic add_fill(logic [7:0] c, int n);
    repeat (n) put_byte(c);
  endtask

  // form-chosen '*' and hex digits over printable bytes after the last '$'
  task automatic add_sum(int form);
    int         k;
    int         from;
    logic [7:0] x;
    from = 0;
    x    = '0;
    foreach (line_q[j]) if (line_q[j] == CH_DOLLAR) from = j;
    for (k = from + 1; k < line_q.size(); k++)
      if (line_q[k] >= CH_SPACE && line_q[k] <= CH_TILDE) x = x ^ line_q[k];
    if (form == SUM_BAD) x = x ^ 8'($urandom_range(1, 255));
    if (form != SUM_NONE) put_byte(CH_STAR);
    case (form)
      SUM_GOOD_UP, SUM_BAD: add_text($sformatf("%02X", x));
      SUM_GOOD_LO:          add_text($sformatf("%02x", x));
      SUM_ONE_DIGIT:        add_text($sformatf("%1X", x[7:4]));
      default: ;
    endcase
  endtask

  // one word onto the byte port, with an optional idle gap first
  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    if (b != CH_CR) n_sent = n_sent + 1;
  endtask

  task automatic send_queued();
    int k;
    for (k = 0; k < line_q.size(); k++) send_byte(line_q[k]);
    line_q.delete();
  endtask

  task automatic sentence(string body, int form);
    add_text(body);
    add_sum(form);
    add_text("\r\n");
    send_queued();
  endtask

  function automatic logic [7:0] field_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 14) return 8'h41 + 8'($urandom_range(0, 25));
    if (r < 16) return 8'h2E;
    return 8'($urandom_range(32, 126));
  endfunction

  // well-formed sentence with random content and checksum form
  task automatic build_sentence();
    int   nf;
    int   r;
    string tag;
    put_byte(CH_DOLLAR);
    put_byte(8'h41 + 8'($urandom_range(0, 25)));
    put_byte(8'h41 + 8'($urandom_range(0, 25)));
    case ($urandom_range(0, 4))
      0: tag = "GGA";
      1: tag = "RMC";
      2: tag = "GSA";
      3: tag = "GSV";
      default: tag = "XYZ";
    endcase
    add_text(tag);
    nf = $urandom_range(0, 6);
    repeat (nf) begin
      put_byte(CH_COMMA);
      repeat ($urandom_range(0, 6)) put_byte(field_char());
    end
    r = $urandom_range(0, 99);
    if (r < 55) add_sum(SUM_GOOD_UP);
    else if (r < 65) add_sum(SUM_GOOD_LO);
    else if (r < 80) add_sum(SUM_BAD);
    else if (r < 90) add_sum(SUM_NONE);
    else if (r < 95) add_sum(SUM_ONE_DIGIT);
    else add_sum(SUM_STAR_ONLY);
    if ($urandom_range(0, 9) < 7) put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  // short printable junk, sometimes anchored by '$'
  task automatic build_noise_line();
    if ($urandom_range(0, 1)) put_byte(CH_DOLLAR);
    repeat ($urandom_range(0, 12)) put_byte(8'($urandom_range(32, 126)));
    put_byte(CH_LF);
  endtask

  task automatic build_raw();
    repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic run_directed();
    // each type tag and each checksum form
    sentence("$GPGGA,123519,4807.038,N,01131.000,E", SUM_GOOD_UP);
    sentence("$GNRMC,225446,A,4916.45,N", SUM_GOOD_LO);
    sentence("$GPGSA,A,3,04,05", SUM_BAD);
    sentence("$GLGSV,3,1,11", SUM_NONE);
    sentence("$GPXYZ,1,2", SUM_GOOD_UP);
    sentence("$GPGSV,1", SUM_ONE_DIGIT);
    sentence("$GPRMC,7", SUM_STAR_ONLY);
    // comma too early or missing
    sentence("$GP,GGA,1", SUM_GOOD_UP);
    sentence("$GPG,GA,1", SUM_GOOD_UP);
    sentence("$GPGG,A,1", SUM_GOOD_UP);
    sentence("$GPGGA123", SUM_GOOD_UP);
    // star too early, star at the last early index, a late star
    add_text("$G*12,GGA,1\r\n");
    send_queued();
    sentence("$AB", SUM_GOOD_UP);
    sentence("$ABC,1", SUM_GOOD_UP);
    // too short, exactly long enough, no leading '$'
    add_text("$GGA\n$GPGG\n$GPGGA\nGPGGA,1,2*00\nx$GPGGA,12\n\n\r\n");
    send_queued();
    // type priority and the prefix limit
    sentence("$GSVRMCGGA,1", SUM_GOOD_UP);
    sentence("$GSVRMC,1", SUM_GOOD_UP);
    sentence("$GSAGSV,1", SUM_GOOD_UP);
    add_text("$");
    add_fill(8'h58, 28);
    sentence("GGA,1", SUM_GOOD_UP);
    add_text("$");
    add_fill(8'h58, 29);
    sentence("GGA,1", SUM_GOOD_UP);
    // dropped control and high bytes, a '$' mid-line
    add_text("$GP");
    put_byte(8'h00);
    put_byte(8'h7F);
    put_byte(8'h80);
    put_byte(8'hFF);
    put_byte(8'h1F);
    put_byte(8'h09);
    sentence("RMC,1", SUM_GOOD_UP);
    add_text("$GP");
    sentence("$GGA,1", SUM_BAD);
    // overfull line, then a '$' restart on a full line
    add_text("$GPRMC,");
    add_fill(8'h41, 506);
    add_text("\n");
    send_queued();
    add_text("$");
    add_fill(8'h42, 512);
    sentence("$GPGSA,9", SUM_GOOD_UP);
  endtask

  // result side: check accepted verdicts, drive stall for the next cycle
  initial begin
    verdict_t got;
    int       hold_left;
    sb        = new();
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind = out_sentence_kind;
        got.cs   = out_checksum_state;
        got.acc  = out_accepted;
        got.len  = out_sentence_length;
        got.gga  = out_gga_count;
        got.rmc  = out_rmc_count;
        got.gsa  = out_gsa_count;
        got.gsv  = out_gsv_count;
        got.err  = out_checksum_error_count;
        sb.check_verdict(got);
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_go) begin
        hold_go   = 0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // reset, directed lines, random stream, drain
  initial begin
    int base_bytes;
    int phase;
    int pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();

    // sender mostly idle, receiver mostly ready
    send_idle_pct  = 74;
    recv_stall_pct = 16;
    phase          = 1;
    base_bytes     = n_sent;
    while (n_sent - base_bytes < RANDOM_BYTES) begin
      if (phase == 1 && n_sent - base_bytes >= PHASE2_BYTES) begin
        // long result hold while the byte side keeps streaming
        phase          = 2;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1;
        build_sentence();
        send_queued();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) build_sentence();
      else if (pick < 90) build_noise_line();
      else build_raw();
      send_queued();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
